// ----- src/ftvd_pkg.sv -----
// ----------------------------------------------------------------------------
// ftvd_pkg
// shared constants and types of the fan triangulator with vertex dedup
// ----------------------------------------------------------------------------
package ftvd_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned INDEX_BITS  = 21;
  localparam int unsigned FIELD_W     = 21;
  localparam int unsigned VIDX_W      = 12;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_SAT   = 2'd2;

  typedef logic [INDEX_BITS-1:0] index_t;

  typedef struct packed {
    index_t n;
    index_t t;
    index_t p;
  } key_t;

  typedef struct packed {
    logic [FIELD_W-1:0] position_index;
    logic [FIELD_W-1:0] texcoord_index;
    logic [FIELD_W-1:0] normal_index;
    logic               first_of_face;
    logic               new_object;
  } corner_t;

  typedef struct packed {
    logic [VIDX_W-1:0]  vertex_index;
    logic               is_new_vertex;
    logic [FIELD_W-1:0] position_slot;
    logic [FIELD_W-1:0] texcoord_slot;
    logic [FIELD_W-1:0] normal_slot;
    logic               table_full;
    logic               last_of_run;
  } result_t;

  typedef enum logic [1:0] {
    SEL_FIRST    = 2'd0,
    SEL_CURRENT  = 2'd1,
    SEL_PREVIOUS = 2'd2
  } lookup_sel_e;

  typedef struct packed {
    logic take_item;
    logic read_entry;
    logic check_entry;
    logic append;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic emits;
    logic scan_end;
    logic hit;
    logic last_lookup;
    logic out_free;
  } status_t;

endpackage

// ----- src/ftvd_if.sv -----
// ----------------------------------------------------------------------------
// ftvd channels
// valid/ready channels for face corners and resolved triangle indices
// ----------------------------------------------------------------------------
interface ftvd_corner_if;
  import ftvd_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] position_index;
  logic [FIELD_W-1:0] texcoord_index;
  logic [FIELD_W-1:0] normal_index;
  logic               first_of_face;
  logic               new_object;

  modport source (
    output valid, position_index, texcoord_index, normal_index, first_of_face, new_object,
    input  ready
  );

  modport sink (
    input  valid, position_index, texcoord_index, normal_index, first_of_face, new_object,
    output ready
  );
endinterface

interface ftvd_index_if;
  import ftvd_pkg::*;

  logic               valid;
  logic               ready;
  logic [VIDX_W-1:0]  vertex_index;
  logic               is_new_vertex;
  logic [FIELD_W-1:0] position_slot;
  logic [FIELD_W-1:0] texcoord_slot;
  logic [FIELD_W-1:0] normal_slot;
  logic               table_full;
  logic               last_of_run;

  modport source (
    output valid, vertex_index, is_new_vertex, position_slot, texcoord_slot, normal_slot,
           table_full, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, vertex_index, is_new_vertex, position_slot, texcoord_slot, normal_slot,
           table_full, last_of_run,
    output ready
  );
endinterface

// ----- src/fan_triangulate_vertex_dedup.sv -----
// sequence: a corner that closes no triangle is taken in the idle state; a corner that closes a triangle
// gives three results, each found by a linear scan that reads and then checks one entry at a time
// and appends the key on a miss; a new corner is taken only after the third result is handed off,
// and each result waits in the emit state while the output register holds an untaken result
// reset: control state clears asynchronously; table contents are not cleared, only
// entries below the count are compared
// ----------------------------------------------------------------------------
// fan_triangulate_vertex_dedup
// fan triangulation of face corners with vertex deduplication per object
// ----------------------------------------------------------------------------
module fan_triangulate_vertex_dedup (
  input  logic           clk_i,
  input  logic           rst_ni,
  ftvd_corner_if.sink    corner_i,
  ftvd_index_if.source   index_o
);
  import ftvd_pkg::*;

  corner_t corner;
  result_t result;
  cmd_t    cmd;
  status_t status;
  logic    result_valid;

  assign corner.position_index = corner_i.position_index;
  assign corner.texcoord_index = corner_i.texcoord_index;
  assign corner.normal_index   = corner_i.normal_index;
  assign corner.first_of_face  = corner_i.first_of_face;
  assign corner.new_object     = corner_i.new_object;

  ftvd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (corner_i.valid),
    .status_i   (status),
    .in_ready_o (corner_i.ready),
    .cmd_o      (cmd)
  );

  ftvd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .corner_i       (corner),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result),
    .result_valid_o (result_valid),
    .result_ready_i (index_o.ready)
  );

  assign index_o.valid         = result_valid;
  assign index_o.vertex_index  = result.vertex_index;
  assign index_o.is_new_vertex = result.is_new_vertex;
  assign index_o.position_slot = result.position_slot;
  assign index_o.texcoord_slot = result.texcoord_slot;
  assign index_o.normal_slot   = result.normal_slot;
  assign index_o.table_full    = result.table_full;
  assign index_o.last_of_run   = result.last_of_run;

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take_item, cmd.read_entry, cmd.check_entry, cmd.append, cmd.emit}))
    else $error("more than one datapath command at once");

  a_append_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.append |-> status.scan_end)
    else $error("append before the scan reached the entry count");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_last_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.last_lookup) |=> corner_i.ready)
    else $error("intake not reopened after the third result");
`endif

endmodule

// ----- src/ftvd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ftvd_ctrl
// sequencer: corner intake, table scan per lookup, result hand-off
// ----------------------------------------------------------------------------
module ftvd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ftvd_pkg::status_t status_i,
  output logic             in_ready_o,
  output ftvd_pkg::cmd_t    cmd_o
);
  import ftvd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          if (status_i.emits) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_end) begin
          cmd_o.append = 1'b1;
          state_d      = ST_EMIT;
        end else begin
          cmd_o.read_entry = 1'b1;
          state_d          = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check_entry = 1'b1;
        state_d = status_i.hit ? ST_EMIT : ST_SCAN;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = status_i.last_lookup ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/ftvd_datapath.sv -----
// ----------------------------------------------------------------------------
// ftvd_datapath
// fan corner registers, unique corner table with linear scan, output register
// ----------------------------------------------------------------------------
module ftvd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ftvd_pkg::corner_t corner_i,
  input  ftvd_pkg::cmd_t    cmd_i,
  output ftvd_pkg::status_t status_o,
  output ftvd_pkg::result_t result_o,
  output logic              result_valid_o,
  input  logic              result_ready_i
);
  import ftvd_pkg::*;

  key_t              table_q [TABLE_DEPTH];
  key_t              rd_q;
  key_t              key_q;
  key_t              first_q;
  key_t              prev_q;
  key_t              old_prev_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  scan_q;
  logic [1:0]        pos_q;
  lookup_sel_e       sel_q;
  logic [ADDR_W-1:0] res_idx_q;
  logic              res_new_q;
  logic              res_full_q;
  result_t           out_q;
  logic              out_valid_q;

  key_t       in_key;
  logic       face_start;
  logic [1:0] pos_eff;
  logic       at_limit;
  result_t    res_next;

  assign in_key.p   = corner_i.position_index[INDEX_BITS-1:0];
  assign in_key.t   = corner_i.texcoord_index[INDEX_BITS-1:0];
  assign in_key.n   = corner_i.normal_index[INDEX_BITS-1:0];
  assign face_start = corner_i.first_of_face | corner_i.new_object;
  assign pos_eff    = face_start ? POS_START : pos_q;
  assign at_limit   = (cnt_q == CNT_W'(TABLE_DEPTH));

  assign status_o.emits       = (pos_eff == POS_SAT);
  assign status_o.scan_end    = (scan_q == cnt_q);
  assign status_o.hit         = (rd_q == key_q);
  assign status_o.last_lookup = (sel_q == SEL_PREVIOUS);
  assign status_o.out_free    = !out_valid_q || result_ready_i;

  always_comb begin
    res_next.vertex_index  = VIDX_W'(res_idx_q);
    res_next.is_new_vertex = res_new_q;
    res_next.position_slot = FIELD_W'(key_q.p - index_t'(1));
    res_next.texcoord_slot = FIELD_W'(key_q.t - index_t'(1));
    res_next.normal_slot   = FIELD_W'(key_q.n - index_t'(1));
    res_next.table_full    = res_full_q;
    res_next.last_of_run   = (sel_q == SEL_PREVIOUS);
  end

  assign result_o       = out_q;
  assign result_valid_o = out_valid_q;

  // table storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_entry) begin
      rd_q <= table_q[scan_q[ADDR_W-1:0]];
    end
    if (cmd_i.append && !at_limit) begin
      table_q[cnt_q[ADDR_W-1:0]] <= key_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      scan_q      <= '0;
      pos_q       <= POS_START;
      sel_q       <= SEL_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_item) begin
        if (corner_i.new_object) begin
          cnt_q <= '0;
        end
        pos_q  <= (pos_eff == POS_SAT) ? POS_SAT : pos_eff + 2'd1;
        scan_q <= '0;
        sel_q  <= SEL_FIRST;
      end
      if (cmd_i.append && !at_limit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.check_entry && !status_o.hit) begin
        scan_q <= scan_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        scan_q      <= '0;
        out_valid_q <= 1'b1;
        case (sel_q)
          SEL_FIRST:   sel_q <= SEL_CURRENT;
          SEL_CURRENT: sel_q <= SEL_PREVIOUS;
          default:     sel_q <= SEL_FIRST;
        endcase
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      if (pos_eff == POS_START) begin
        first_q <= in_key;
      end
      prev_q     <= in_key;
      old_prev_q <= prev_q;
      key_q      <= first_q;
    end
    if (cmd_i.check_entry && status_o.hit) begin
      res_idx_q  <= scan_q[ADDR_W-1:0];
      res_new_q  <= 1'b0;
      res_full_q <= 1'b0;
    end
    if (cmd_i.append) begin
      res_idx_q  <= at_limit ? '0 : cnt_q[ADDR_W-1:0];
      res_new_q  <= !at_limit;
      res_full_q <= at_limit;
    end
    if (cmd_i.emit) begin
      out_q <= res_next;
      case (sel_q)
        SEL_FIRST:   key_q <= prev_q;
        SEL_CURRENT: key_q <= old_prev_q;
        default:     key_q <= key_q;
      endcase
    end
  end

endmodule
